@@ hdl/vzc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the viewport zoom clamp.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vzc_pkg;

    localparam int COORD_INT_BITS  = 16;
    localparam int COORD_FRAC_BITS = 8;
    localparam int FW         = COORD_INT_BITS + COORD_FRAC_BITS;
    // Zoom factor and max scale are unsigned Q8.8.
    localparam int SCALE_FRAC = 8;
    // Working width of the window edges between two saturations.
    localparam int WW         = FW + 16;
    localparam int NUM_W      = FW + 1 + SCALE_FRAC;
    localparam int DEN_W      = 17;
    localparam int CNT_W      = $clog2(NUM_W + 1);

    typedef logic signed [FW-1:0] coord_t;
    typedef logic signed [WW-1:0] wide_t;
    typedef logic signed [15:0]   pix_t;

    localparam wide_t SMAX = wide_t'((64'sd1 <<< (FW - 1)) - 64'sd1);
    localparam wide_t SMIN = wide_t'(-(64'sd1 <<< (FW - 1)));

    localparam pix_t        BOUND_LO_RST  = 16'sd0;
    localparam pix_t        BOUND_HI_RST  = 16'sd1023;
    localparam logic [15:0] ZOOM_CAP_RST  = 16'd5819;

    localparam logic [2:0] REG_BOUND_LEFT   = 3'd0;
    localparam logic [2:0] REG_BOUND_RIGHT  = 3'd1;
    localparam logic [2:0] REG_BOUND_TOP    = 3'd2;
    localparam logic [2:0] REG_BOUND_BOTTOM = 3'd3;
    localparam logic [2:0] REG_ZOOM_CAP     = 3'd4;

    typedef logic [3:0] lane_op_t;
    localparam lane_op_t OP_NONE   = 4'd0;
    localparam lane_op_t OP_LOAD   = 4'd1;
    localparam lane_op_t OP_ZSTART = 4'd2;
    localparam lane_op_t OP_ZEND   = 4'd3;
    localparam lane_op_t OP_CORNER = 4'd4;
    localparam lane_op_t OP_FIT_A  = 4'd5;
    localparam lane_op_t OP_FIT_B  = 4'd6;
    localparam lane_op_t OP_WSTART = 4'd7;
    localparam lane_op_t OP_WEND   = 4'd8;
    localparam lane_op_t OP_COMMIT = 4'd9;

    typedef struct packed {
        logic               action;
        logic [15:0]        factor;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
    } vzc_in_t;

    typedef struct packed {
        logic               changed;
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic signed [15:0] out_top;
        logic signed [15:0] out_bottom;
    } vzc_out_t;

    typedef struct packed {
        lane_op_t    op;
        logic [15:0] factor;
        logic [15:0] zoom_cap;
    } lane_cmd_t;

    typedef struct packed {
        logic   div_done;
        logic   changed;
        coord_t commit_a;
        coord_t commit_b;
    } lane_stat_t;

    typedef struct packed {
        wide_t a;
        wide_t b;
    } wpair_t;

    function automatic coord_t sat_fw(wide_t v);
        if (v > SMAX) begin
            return coord_t'(SMAX);
        end else if (v < SMIN) begin
            return coord_t'(SMIN);
        end
        return coord_t'(v);
    endfunction

    function automatic wide_t pix_to_wide(pix_t p);
        wide_t t;
        t = wide_t'(p) <<< COORD_FRAC_BITS;
        return wide_t'(sat_fw(t));
    endfunction

    // Push the window up from the low bound, then crop at the high bound.
    function automatic wpair_t fit_low(wide_t a, wide_t b, wide_t lo, wide_t hi);
        wpair_t r;
        wide_t  nb;
        r.a = a;
        r.b = b;
        if (a < lo) begin
            nb = b + (lo - a);
            r.b = (nb > hi) ? hi : nb;
            r.a = lo;
        end
        return r;
    endfunction

    // Push the window down from the high bound, then crop at the low bound.
    function automatic wpair_t fit_high(wide_t a, wide_t b, wide_t lo, wide_t hi);
        wpair_t r;
        wide_t  na;
        r.a = a;
        r.b = b;
        if (b > hi) begin
            na = a + (hi - b);
            r.a = (na < lo) ? lo : na;
            r.b = hi;
        end
        return r;
    endfunction

    // Truncate toward zero to whole pixels and saturate to 16 bits.
    function automatic pix_t to_pix(coord_t v);
        wide_t t;
        t = wide_t'(v);
        if (v < 0) begin
            t = t + wide_t'((64'sd1 <<< COORD_FRAC_BITS) - 64'sd1);
        end
        t = t >>> COORD_FRAC_BITS;
        if (t > wide_t'(32767)) begin
            return 16'sh7fff;
        end else if (t < wide_t'(-32768)) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/vzc_div.sv @@
// Bit-serial restoring divider: one quotient bit per clock.
// Depends on vzc_pkg for its widths.
`default_nettype none

module vzc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [vzc_pkg::NUM_W-1:0]  num,
    input  wire logic [vzc_pkg::DEN_W-1:0]  den,
    output logic      [vzc_pkg::NUM_W-1:0]  quo,
    output logic      [vzc_pkg::DEN_W-1:0]  rem,
    output logic                            done
);
    import vzc_pkg::*;

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] qs_reg, qs_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   shifted, diff;
    logic             ge;

    always_comb begin
        shifted  = {rem_reg, qs_reg[NUM_W-1]};
        ge       = shifted >= {1'b0, den_reg};
        diff     = shifted - {1'b0, den_reg};
        rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        qs_next  = {qs_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            qs_reg  <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            qs_reg  <= qs_next;
        end
    end

    assign quo  = qs_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ hdl/vzc_lane.sv @@
// One axis of the window: committed edges, working edges, fit and widen steps.
// Depends on vzc_pkg and instantiates vzc_div.
`default_nettype none

module vzc_lane (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                high_first,
    input  wire vzc_pkg::lane_cmd_t  cmd,
    input  wire vzc_pkg::pix_t       bound_lo,
    input  wire vzc_pkg::pix_t       bound_hi,
    input  wire vzc_pkg::coord_t     center,
    input  wire vzc_pkg::pix_t       corner1,
    input  wire vzc_pkg::pix_t       corner2,
    output vzc_pkg::lane_stat_t      stat
);
    import vzc_pkg::*;

    coord_t win_a_reg, win_b_reg;
    wide_t  a_reg, b_reg, a_next, b_next;

    wide_t             lo, hi, span, smag, wdiff, wmag, q_w, q_s, w, d, h, c_w;
    logic              sneg, rnz, over, div_start, div_done;
    logic [NUM_W-1:0]  div_num, quo;
    logic [DEN_W-1:0]  div_den, rem;
    pix_t              cmin, cmax;
    wpair_t            fl, fh;

    always_comb begin
        lo    = pix_to_wide(bound_lo);
        hi    = pix_to_wide(bound_hi);
        span  = hi - lo;
        sneg  = span[WW-1];
        smag  = sneg ? -span : span;
        wdiff = wide_t'(win_b_reg) - wide_t'(win_a_reg);
        wmag  = wdiff[WW-1] ? -wdiff : wdiff;
        c_w   = wide_t'(center);
        cmin  = (corner1 < corner2) ? corner1 : corner2;
        cmax  = (corner1 < corner2) ? corner2 : corner1;

        div_start = (cmd.op == OP_ZSTART) || (cmd.op == OP_WSTART);
        if (cmd.op == OP_ZSTART) begin
            div_num = {wmag[FW:0], {SCALE_FRAC{1'b0}}};
            div_den = (cmd.factor == 16'd0) ? DEN_W'(2) : {cmd.factor, 1'b0};
        end else begin
            div_num = {smag[FW:0], {SCALE_FRAC{1'b0}}};
            div_den = (cmd.zoom_cap == 16'd0) ? DEN_W'(1) : {1'b0, cmd.zoom_cap};
        end

        // Signed quotient of bounds size by max scale; only whether the
        // remainder is nonzero matters for the compare.
        q_w = $signed({{(WW-NUM_W){1'b0}}, quo});
        q_s = sneg ? -q_w : q_w;
        rnz = (rem != '0);
        w   = b_reg - a_reg;
        if (!w[WW-1] && (w != '0)) begin
            over = (q_s > w) || ((q_s == w) && rnz && !sneg);
        end else if (w[WW-1]) begin
            over = (q_s < w) || ((q_s == w) && rnz && sneg);
        end else begin
            over = (span > 0);
        end
        d = q_s - w;
        h = (d + $signed({{(WW-1){1'b0}}, d[WW-1]})) >>> 1;

        fl = fit_low(a_reg, b_reg, lo, hi);
        fh = fit_high(a_reg, b_reg, lo, hi);

        a_next = a_reg;
        b_next = b_reg;
        case (cmd.op)
            OP_ZEND: begin
                a_next = c_w - q_w;
                b_next = c_w + q_w;
            end
            OP_CORNER: begin
                a_next = pix_to_wide(cmin);
                b_next = pix_to_wide(cmax);
            end
            OP_FIT_A: begin
                a_next = high_first ? fh.a : fl.a;
                b_next = high_first ? fh.b : fl.b;
            end
            OP_FIT_B: begin
                a_next = high_first ? fl.a : fh.a;
                b_next = high_first ? fl.b : fh.b;
            end
            OP_WEND: begin
                if (over) begin
                    a_next = a_reg - h;
                    b_next = b_reg + h;
                end
            end
            default: begin
            end
        endcase
    end

    vzc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (quo),
        .rem     (rem),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_a_reg <= sat_fw(pix_to_wide(BOUND_LO_RST));
            win_b_reg <= sat_fw(pix_to_wide(BOUND_HI_RST));
        end else if (cmd.op == OP_LOAD) begin
            win_a_reg <= sat_fw(lo);
            win_b_reg <= sat_fw(hi);
        end else if (cmd.op == OP_COMMIT) begin
            win_a_reg <= stat.commit_a;
            win_b_reg <= stat.commit_b;
        end
    end

    always_comb begin
        stat.div_done = div_done;
        stat.commit_a = sat_fw(a_reg);
        stat.commit_b = sat_fw(b_reg);
        stat.changed  = (stat.commit_a != win_a_reg) || (stat.commit_b != win_b_reg);
    end

endmodule

`default_nettype wire

@@ hdl/viewport_zoom_clamp.sv @@
// Viewport zoom clamp: one item at a time. The widening check and each zoom run one
// 33-step bit-serial division per axis (both axes in parallel), plus corner, fit,
// widen and commit steps. The next item can be accepted from the cycle after the commit
// (unless a bound reload is pending), even if the last result still waits on m_ready,
// but not before that commit; a new result that meets an unaccepted one waits in the
// commit step. Writing a bound register reloads the window from the bounds once the
// sequencer is idle; no item is accepted while that reload is pending.
// Top level: APB registers and sequencer; depends on vzc_pkg and vzc_lane.
`default_nettype none

module viewport_zoom_clamp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire vzc_pkg::vzc_in_t   s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output vzc_pkg::vzc_out_t       m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    import vzc_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ZSTART = 4'd1;
    localparam logic [3:0] ST_ZWAIT  = 4'd2;
    localparam logic [3:0] ST_CORNER = 4'd3;
    localparam logic [3:0] ST_FIT1   = 4'd4;
    localparam logic [3:0] ST_FIT2   = 4'd5;
    localparam logic [3:0] ST_WSTART = 4'd6;
    localparam logic [3:0] ST_WWAIT  = 4'd7;
    localparam logic [3:0] ST_FIT3   = 4'd8;
    localparam logic [3:0] ST_FIT4   = 4'd9;
    localparam logic [3:0] ST_COMMIT = 4'd10;

    pix_t        bl_reg, br_reg, bt_reg, bb_reg;
    logic [15:0] ms_reg;
    logic        load_pend_reg;
    logic [3:0]  state_reg, state_next;
    vzc_in_t     item_reg;
    logic        m_valid_reg;
    vzc_out_t    m_data_reg;

    logic        wr, bound_wr, both_done, out_free;
    logic [2:0]  idx;
    lane_cmd_t   cmd;
    lane_stat_t  stat_x, stat_y;

    assign pready   = 1'b1;
    assign idx      = paddr[4:2];
    assign wr       = psel && penable && pwrite;
    assign bound_wr = wr && ((idx == REG_BOUND_LEFT) || (idx == REG_BOUND_RIGHT) ||
                             (idx == REG_BOUND_TOP) || (idx == REG_BOUND_BOTTOM));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bl_reg <= BOUND_LO_RST;
            br_reg <= BOUND_HI_RST;
            bt_reg <= BOUND_LO_RST;
            bb_reg <= BOUND_HI_RST;
            ms_reg <= ZOOM_CAP_RST;
        end else if (wr) begin
            case (idx)
                REG_BOUND_LEFT:   bl_reg <= pwdata[15:0];
                REG_BOUND_RIGHT:  br_reg <= pwdata[15:0];
                REG_BOUND_TOP:    bt_reg <= pwdata[15:0];
                REG_BOUND_BOTTOM: bb_reg <= pwdata[15:0];
                REG_ZOOM_CAP:     ms_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BOUND_LEFT:   prdata = {16'b0, bl_reg};
            REG_BOUND_RIGHT:  prdata = {16'b0, br_reg};
            REG_BOUND_TOP:    prdata = {16'b0, bt_reg};
            REG_BOUND_BOTTOM: prdata = {16'b0, bb_reg};
            REG_ZOOM_CAP:     prdata = {16'b0, ms_reg};
            default:          prdata = 32'b0;
        endcase
    end

    assign both_done = stat_x.div_done && stat_y.div_done;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && !load_pend_reg;

    always_comb begin
        state_next    = state_reg;
        cmd.op        = OP_NONE;
        cmd.factor    = item_reg.factor;
        cmd.zoom_cap  = ms_reg;
        case (state_reg)
            ST_IDLE: begin
                if (load_pend_reg) begin
                    cmd.op = OP_LOAD;
                end else if (s_valid) begin
                    state_next = s_data.action ? ST_CORNER : ST_ZSTART;
                end
            end
            ST_ZSTART: begin
                cmd.op     = OP_ZSTART;
                state_next = ST_ZWAIT;
            end
            ST_ZWAIT: begin
                if (both_done) begin
                    cmd.op     = OP_ZEND;
                    state_next = ST_FIT1;
                end
            end
            ST_CORNER: begin
                cmd.op     = OP_CORNER;
                state_next = ST_FIT1;
            end
            ST_FIT1: begin
                cmd.op     = OP_FIT_A;
                state_next = ST_FIT2;
            end
            ST_FIT2: begin
                cmd.op     = OP_FIT_B;
                state_next = ST_WSTART;
            end
            ST_WSTART: begin
                cmd.op     = OP_WSTART;
                state_next = ST_WWAIT;
            end
            ST_WWAIT: begin
                if (both_done) begin
                    cmd.op     = OP_WEND;
                    state_next = ST_FIT3;
                end
            end
            ST_FIT3: begin
                cmd.op     = OP_FIT_A;
                state_next = ST_FIT4;
            end
            ST_FIT4: begin
                cmd.op     = OP_FIT_B;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.op     = OP_COMMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            load_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (bound_wr) begin
                load_pend_reg <= 1'b1;
            end else if (state_reg == ST_IDLE) begin
                load_pend_reg <= 1'b0;
            end
            if (cmd.op == OP_COMMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (cmd.op == OP_COMMIT) begin
            m_data_reg.changed    <= stat_x.changed || stat_y.changed;
            m_data_reg.out_left   <= to_pix(stat_x.commit_a);
            m_data_reg.out_right  <= to_pix(stat_x.commit_b);
            m_data_reg.out_top    <= to_pix(stat_y.commit_a);
            m_data_reg.out_bottom <= to_pix(stat_y.commit_b);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Horizontal edges fit from the low side first, vertical from the high side.
    vzc_lane u_lane_x (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .high_first (1'b0),
        .cmd        (cmd),
        .bound_lo   (bl_reg),
        .bound_hi   (br_reg),
        .center     (item_reg.center_x),
        .corner1    (item_reg.first_x),
        .corner2    (item_reg.second_x),
        .stat       (stat_x)
    );

    vzc_lane u_lane_y (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .high_first (1'b1),
        .cmd        (cmd),
        .bound_lo   (bt_reg),
        .bound_hi   (bb_reg),
        .center     (item_reg.center_y),
        .corner1    (item_reg.first_y),
        .corner2    (item_reg.second_y),
        .stat       (stat_y)
    );

endmodule

`default_nettype wire

@@ hdl/vzc_check.sv @@
// Port-level checks for the viewport zoom clamp, bound onto the top level.
// Depends on vzc_pkg and viewport_zoom_clamp.
`default_nettype none

module vzc_check (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire vzc_pkg::vzc_out_t  m_data,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [4:0]         paddr,
    input wire logic               pready
);

    // A result waiting on the consumer holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

    // No result can appear in the cycle right after an item is taken.
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

    // A bound write reloads the window before the next item is taken.
    a_bound_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready &&
        (paddr[4:2] <= vzc_pkg::REG_BOUND_BOTTOM) |=> !s_ready)
        else $error("item accepted before window reload");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind viewport_zoom_clamp vzc_check u_vzc_check (.*);

`default_nettype wire
